@@ src/wpc_pkg.sv @@
// ----------------------------------------------------------------------------
// wpc_pkg: shared types and constants for the window pattern counter
// Holds the transfer payload structs and the default sizing of the block.
// ----------------------------------------------------------------------------
package wpc_pkg;

  localparam int WORD_W            = 32;
  localparam int MAX_WORDS         = 4;
  localparam int SEGMENT_LEN_DEF   = 2;
  localparam int TABLE_ENTRIES_DEF = 3;

  // One stream value, with the end mark that starts a table dump.
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     end_of_stream;
  } in_t;

  // One table entry on a dump, oldest entry first.
  typedef struct packed {
    logic        [3:0]        entry_index;
    logic signed [WORD_W-1:0] word_0;
    logic signed [WORD_W-1:0] word_1;
    logic signed [WORD_W-1:0] word_2;
    logic signed [WORD_W-1:0] word_3;
    logic        [WORD_W-1:0] occurrences;
    logic                     last_entry;
  } out_t;

endpackage

@@ src/window_pattern_counter.sv @@
// ----------------------------------------------------------------------------
// window_pattern_counter: sliding-window segment occurrence counter
// Counts overlapping runs of SEGMENT_LEN values against a FIFO-evicted table
// held in a synchronous RAM, and dumps the table on an end-marked value.
// ----------------------------------------------------------------------------
//
//  channel   | direction | signals                           | payload
//  ----------+-----------+-----------------------------------+--------------
//  item      | in        | item_valid, item_ready, item      | wpc_pkg::in_t
//  result    | out       | result_valid, result_ready,result | wpc_pkg::out_t
//
//  Sequence: take a value, then a scan reading one entry per cycle from the
//  table RAM until the first hit or past the last used entry; a dump reads
//  each table slot in turn and loads it into the result register.
//  Reset: clear fill, entry count and ring head; leave the table RAM as is.
//  Stalls: take a value only while no scan or dump runs; a waiting result
//  stalls only the dump, not the next value.
//
module window_pattern_counter #(
  parameter int SEGMENT_LEN   = wpc_pkg::SEGMENT_LEN_DEF,
  parameter int TABLE_ENTRIES = wpc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  wpc_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_ready,
  output wpc_pkg::out_t result
);

  localparam int WW      = wpc_pkg::WORD_W;
  localparam int SEG_W   = SEGMENT_LEN * WW;
  localparam int ENTRY_W = SEG_W + WW;
  localparam int ADDR_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int FILL_W  = $clog2(SEGMENT_LEN + 1);

  // sequencer codes
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_DUMP_RD = 2'd2;
  localparam logic [1:0] ST_DUMP_WR = 2'd3;

  // Logical entry idx (0 = oldest) lives at (head + idx) mod TABLE_ENTRIES,
  // so FIFO eviction is a head advance and the survivors keep their order.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] hd,
                                                  input logic [CNT_W-1:0]  idx);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(hd) + SUM_W'(idx);
    if (sum >= SUM_W'(TABLE_ENTRIES)) begin
      sum = sum - SUM_W'(TABLE_ENTRIES);
    end
    return ADDR_W'(sum);
  endfunction

  // control state
  logic [1:0]        state;
  logic [FILL_W-1:0] fill;
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  dump_idx;
  logic              cmp_vld;
  logic [ADDR_W-1:0] cmp_addr;
  logic              hold_last;

  // window shift line, oldest value at index 0
  logic [WW-1:0]     win [SEGMENT_LEN];
  logic [SEG_W-1:0]  win_flat;

  // table RAM
  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_we;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic              item_fire;
  logic              out_free;
  logic              issue;
  logic              hit;
  logic              miss;
  logic [WW-1:0]     cnt_old;
  logic [WW-1:0]     cnt_new;
  logic [FILL_W-1:0] fill_next;
  logic              dump_valid;
  logic              dump_last;
  logic [WW-1:0]     dump_words [wpc_pkg::MAX_WORDS];
  wpc_pkg::out_t     result_next;

  assign item_ready = (state == ST_IDLE);
  assign item_fire  = item_valid & item_ready;
  assign out_free   = !result_valid | result_ready;

  always_comb begin
    for (int k = 0; k < SEGMENT_LEN; k++) begin
      win_flat[k*WW +: WW] = win[k];
    end
  end

  // Scan pipeline: read entry rd_idx while comparing the entry read last cycle.
  assign issue   = (state == ST_SCAN) && !hit && (rd_idx < used);
  assign hit     = (state == ST_SCAN) && cmp_vld && (rd_data[SEG_W-1:0] == win_flat);
  assign miss    = (state == ST_SCAN) && !cmp_vld && (rd_idx == used);
  assign cnt_old = rd_data[SEG_W +: WW];
  assign cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + WW'(1);

  assign fill_next = (fill == FILL_W'(SEGMENT_LEN)) ? fill : fill + FILL_W'(1);

  assign dump_valid = (dump_idx < used);
  assign dump_last  = (dump_idx == CNT_W'(TABLE_ENTRIES - 1));

  // RAM port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = phys_addr(head, rd_idx);
    mem_we  = 1'b0;
    wr_addr = cmp_addr;
    wr_data = {cnt_new, rd_data[SEG_W-1:0]};
    if (state == ST_DUMP_RD) begin
      rd_en   = 1'b1;
      rd_addr = phys_addr(head, dump_idx);
    end else if (issue) begin
      rd_en = 1'b1;
    end
    if (hit) begin
      mem_we = 1'b1;
    end else if (miss) begin
      mem_we  = 1'b1;
      wr_data = {WW'(1), win_flat};
      // a full table overwrites the oldest slot, which is the head
      wr_addr = (used == CNT_W'(TABLE_ENTRIES)) ? head : phys_addr(head, used);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Dump payload: entries never filled, and words past the segment, read zero.
  always_comb begin
    for (int k = 0; k < wpc_pkg::MAX_WORDS; k++) begin
      dump_words[k] = '0;
      if (k < SEGMENT_LEN && dump_valid) begin
        dump_words[k] = rd_data[k*WW +: WW];
      end
    end
    result_next.entry_index = 4'(dump_idx);
    result_next.word_0      = dump_words[0];
    result_next.word_1      = dump_words[1];
    result_next.word_2      = dump_words[2];
    result_next.word_3      = dump_words[3];
    result_next.occurrences = dump_valid ? cnt_old : '0;
    result_next.last_entry  = dump_last;
  end

  // Window shift line: payload only, the fill count says what is valid.
  always_ff @(posedge clk) begin
    if (item_fire) begin
      for (int k = 0; k < SEGMENT_LEN - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[SEGMENT_LEN-1] <= item.value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == ST_DUMP_WR && out_free) begin
      result <= result_next;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      head         <= '0;
      used         <= '0;
      rd_idx       <= '0;
      dump_idx     <= '0;
      cmp_vld      <= 1'b0;
      cmp_addr     <= '0;
      hold_last    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      cmp_vld <= issue;
      if (issue) begin
        cmp_addr <= rd_addr;
        rd_idx   <= rd_idx + CNT_W'(1);
      end
      // Load on a free slot, else drop valid once the result is taken.
      if (state == ST_DUMP_WR && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_fire) begin
            fill      <= fill_next;
            hold_last <= item.end_of_stream;
            rd_idx    <= '0;
            dump_idx  <= '0;
            if (fill_next == FILL_W'(SEGMENT_LEN)) begin
              state <= ST_SCAN;
            end else if (item.end_of_stream) begin
              state <= ST_DUMP_RD;
            end
          end
        end
        ST_SCAN: begin
          if (miss) begin
            if (used == CNT_W'(TABLE_ENTRIES)) begin
              // evict: advance head past the slot just overwritten
              head <= (head == ADDR_W'(TABLE_ENTRIES - 1)) ? '0 : head + ADDR_W'(1);
            end else begin
              used <= used + CNT_W'(1);
            end
          end
          if (hit || miss) begin
            state <= hold_last ? ST_DUMP_RD : ST_IDLE;
          end
        end
        ST_DUMP_RD: begin
          state <= ST_DUMP_WR;
        end
        ST_DUMP_WR: begin
          if (out_free) begin
            if (dump_last) begin
              state <= ST_IDLE;
            end else begin
              dump_idx <= dump_idx + CNT_W'(1);
              state    <= ST_DUMP_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count exceeds table size");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({hit, miss}))
    else $error("hit and insert in the same cycle");

  a_no_write_in_dump: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP_RD || state == ST_DUMP_WR) |-> !mem_we)
    else $error("table written during dump");

  a_used_moves_on_insert: assert property (@(posedge clk) disable iff (rst)
    (used != $past(used)) |-> $past(miss))
    else $error("entry count changed without an insert");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(result))
    else $error("result overwritten while waiting");

endmodule

@@ tb/window_pattern_counter_tb.sv @@
// ----------------------------------------------------------------------------
// window_pattern_counter_tb: self-checking bench for the window pattern counter
// Feeds signed values through the item channel and tracks the sliding window
// and the FIFO-evicted segment table alongside the block. Every dump entry is
// checked field by field against the tracked table. Random gaps fall on both
// channels, with calm stretches that run at full rate.
// ----------------------------------------------------------------------------
module window_pattern_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_W     = wpc_pkg::WORD_W;
  localparam int SEG        = wpc_pkg::SEGMENT_LEN_DEF;
  localparam int ENT        = wpc_pkg::TABLE_ENTRIES_DEF;
  localparam int STALL_LIMIT = 2000;  // idle cycles before the watchdog fires
  localparam int TAIL_CYCLES = 4 * ENT + 16;

  localparam logic signed [WORD_W-1:0] V_MIN = 32'h8000_0000;
  localparam logic signed [WORD_W-1:0] V_MAX = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  wpc_pkg::in_t  item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  wpc_pkg::out_t result;

  // Tracked copy of the block's state.
  logic [SEG-1:0][WORD_W-1:0] win_vals;
  int unsigned                win_fill;
  logic [SEG-1:0][WORD_W-1:0] seg_tab [ENT];
  logic [WORD_W-1:0]          seg_count [ENT];
  int unsigned                seg_used;

  // Dump entries still owed by the block, oldest first.
  wpc_pkg::out_t dump_expected [$];

  bit calm = 1'b0;  // when set, neither side inserts gaps
  int errors = 0;
  int n_items = 0;
  int n_dumps = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_evicts = 0;
  int idle_cycles = 0;

  window_pattern_counter #(
    .SEGMENT_LEN  (SEG),
    .TABLE_ENTRIES(ENT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Shift the value in, count the window once it is full, and queue the
  // table contents when the value carries the end mark.
  task automatic track_value(input logic signed [WORD_W-1:0] v, input logic eos);
    int hit;
    wpc_pkg::out_t r;
    logic [3:0][WORD_W-1:0] w;
    for (int k = 0; k + 1 < SEG; k++) win_vals[k] = win_vals[k+1];
    win_vals[SEG-1] = v;
    if (win_fill < SEG) win_fill++;

    if (win_fill >= SEG) begin
      hit = -1;
      for (int e = 0; e < seg_used; e++) begin
        if (hit < 0 && seg_tab[e] == win_vals) hit = e;
      end
      if (hit >= 0) begin
        n_hits++;
        if (seg_count[hit] != '1) seg_count[hit] = seg_count[hit] + 1;
      end else if (seg_used < ENT) begin
        seg_tab[seg_used]   = win_vals;
        seg_count[seg_used] = 1;
        seg_used++;
      end else begin
        // Evict the oldest entry, keep the order of the rest.
        n_evicts++;
        for (int e = 0; e + 1 < ENT; e++) begin
          seg_tab[e]   = seg_tab[e+1];
          seg_count[e] = seg_count[e+1];
        end
        seg_tab[ENT-1]   = win_vals;
        seg_count[ENT-1] = 1;
      end
    end

    if (eos) begin
      n_dumps++;
      for (int e = 0; e < ENT; e++) begin
        w = '0;
        for (int k = 0; k < 4; k++) begin
          if (e < seg_used && k < SEG) w[k] = seg_tab[e][k];
        end
        r.entry_index = e[3:0];
        r.word_0      = w[0];
        r.word_1      = w[1];
        r.word_2      = w[2];
        r.word_3      = w[3];
        r.occurrences = (e < seg_used) ? seg_count[e] : '0;
        r.last_entry  = (e == ENT - 1);
        dump_expected.push_back(r);
      end
    end
  endtask

  // Send one value; valid stays high afterwards so a back-to-back transfer
  // needs no second assignment in the same step.
  task automatic send_value(input logic signed [WORD_W-1:0] v, input logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{value: v, end_of_stream: eos};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    n_items++;
    track_value(v, eos);
  endtask

  // Drop valid and wait for every owed dump entry.
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (dump_expected.size() != 0) @(posedge clk);
  endtask

  // Dump right away: the window never fills, so the table reads as all zero.
  task automatic test_short_stream();
    send_value(32'sd17, 1'b1);
  endtask

  // One window formed: entry 0 filled, the remaining entries still empty.
  task automatic test_unfilled_entries();
    send_value(V_MIN, 1'b1);
  endtask

  // Alternate the extremes so later windows hit entries other than 0.
  task automatic test_extreme_values();
    send_value(V_MAX, 1'b0);
    send_value(V_MIN, 1'b0);
    send_value(V_MAX, 1'b0);
    send_value(V_MIN, 1'b1);
  endtask

  // Walk the table through misses, evictions and hits, then dump.
  task automatic test_hits_and_eviction();
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd1, 1'b0);
    send_value(32'sd1, 1'b0);
    send_value(32'sd1, 1'b1);
  endtask

  // Two end marks in a row: state carries over past a dump.
  task automatic test_back_to_back_dumps();
    send_value(32'h5555_5555, 1'b1);
    send_value(32'hAAAA_AAAA, 1'b1);
  endtask

  // Hold the sender until every result is in, then continue the stream.
  task automatic test_drain_pause();
    send_value(32'sd3, 1'b0);
    send_value(32'sd4, 1'b1);
    send_value(32'sd3, 1'b0);
    drain_results();
    send_value(32'sd4, 1'b0);
    send_value(32'sd3, 1'b1);
  endtask

  // Phases of random values; each draws mostly from a small pool so windows
  // repeat and hit, with fully random values mixed in as noise.
  task automatic test_random_stream();
    logic signed [WORD_W-1:0] pool [4];
    logic signed [WORD_W-1:0] v;
    for (int ph = 0; ph < 5; ph++) begin
      calm = (ph == 2);
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 7))
          0:       pool[i] = V_MIN;
          1:       pool[i] = V_MAX;
          2:       pool[i] = -32'sd1;
          3:       pool[i] = 32'sd0;
          default: pool[i] = $urandom;
        endcase
      end
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 3) != 0) v = pool[$urandom_range(0, (ph == 1) ? 1 : 3)];
        else v = $urandom;
        send_value(v, ($urandom_range(0, 11) == 0) || (n == 99));
      end
      // Let results catch up between some phases.
      if (ph == 3) drain_results();
    end
    calm = 1'b0;
  endtask

  // Result side: ready high for a while, then a random stall.
  initial begin
    int gap;
    forever begin
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Check each result transfer against the oldest owed entry.
  always @(posedge clk) begin
    wpc_pkg::out_t want;
    if (!rst && result_valid && result_ready) begin
      if (dump_expected.size() == 0) begin
        $error("result transfer with nothing expected: index %0d", result.entry_index);
        errors++;
      end else begin
        want = dump_expected.pop_front();
        n_checked++;
        check_field("entry_index", WORD_W'(want.entry_index),
                    WORD_W'(result.entry_index));
        check_field("word_0", want.word_0, result.word_0);
        check_field("word_1", want.word_1, result.word_1);
        check_field("word_2", want.word_2, result.word_2);
        check_field("word_3", want.word_3, result.word_3);
        check_field("occurrences", want.occurrences, result.occurrences);
        check_field("last_entry", WORD_W'(want.last_entry),
                    WORD_W'(result.last_entry));
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results owed",
               idle_cycles, dump_expected.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    win_vals  = '0;
    win_fill  = 0;
    seg_used  = 0;
    for (int e = 0; e < ENT; e++) begin
      seg_tab[e]   = '0;
      seg_count[e] = '0;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_short_stream();
    test_unfilled_entries();
    test_extreme_values();
    test_hits_and_eviction();
    test_back_to_back_dumps();
    test_drain_pause();
    test_random_stream();

    // Wait out the owed results, then keep watching for stray transfers.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (dump_expected.size() != 0) begin
      $error("%0d dump entries never arrived", dump_expected.size());
      errors++;
    end
    $display("covered %0d values with %0d dumps, %0d entries checked",
             n_items, n_dumps, n_checked);
    $display("table saw %0d hits and %0d evictions, %0d errors",
             n_hits, n_evicts, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
